// ===== sv/chlt_pkg.sv =====
// ----------------------------------------------------------------------------
// chlt_pkg
// Shared types and constants for the CAN heartbeat liveness table.
// ----------------------------------------------------------------------------
package chlt_pkg;

	localparam int SLOTS = 8;

	localparam int ID_W    = 29;
	localparam int DLC_W   = 4;
	localparam int NODE_W  = 8;
	localparam int TIME_W  = 32;
	localparam int KIND_W  = 3;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STOP    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STORED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BAD_DLC = 3'd4;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd5;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd6;

	// Operation codes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_START_ID  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_STOP_ID   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_HB_ID     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_MIN_DLC   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_TIMEOUT   = 3'd4;

	// Probe that travels down the row of slot cells, one cell per cycle
	typedef struct packed {
		logic              vld;    // probe present in this stage
		logic              claim;  // claim pass: first free slot takes the node
		logic              upd;    // lookup pass of a heartbeat: refresh on hit
		logic              found;  // a slot already matched (lookup pass)
		logic              alive;  // age of the matched slot within timeout
		logic              free;   // a free slot was passed (lookup pass)
		logic [NODE_W-1:0] node;
		logic [TIME_W-1:0] now;
	} probe_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_CLAIM,
		ST_DONE
	} state_t;

endpackage

// ===== sv/chlt_cell.sv =====
// ----------------------------------------------------------------------------
// chlt_cell
// One table slot: holds a node id and its last-seen time, examines the
// passing probe and hands it to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module chlt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [chlt_pkg::TIME_W-1:0] timeout_ms,
	input  chlt_pkg::probe_t           probe_in,
	output chlt_pkg::probe_t           probe_out
);
	import chlt_pkg::*;

	logic              valid_q;
	logic [NODE_W-1:0] node_q;
	logic [TIME_W-1:0] last_q;
	probe_t            probe_q;

	logic              hit;
	logic              take;
	logic [TIME_W-1:0] age;
	probe_t            nxt;

	always_comb begin
		hit  = probe_in.vld && !probe_in.claim && !probe_in.found && valid_q
			&& (node_q == probe_in.node);
		take = probe_in.vld && probe_in.claim && !valid_q;
		age  = probe_in.now - last_q;
		nxt  = probe_in;
		if (hit) begin
			nxt.found = 1'b1;
			nxt.alive = (age <= timeout_ms);
		end
		if (!valid_q) begin
			nxt.free = 1'b1;
		end
		// Drop the claim once a slot has taken the node
		if (take) begin
			nxt.claim = 1'b0;
			nxt.vld   = 1'b1;
			nxt.found = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			probe_q <= '0;
		end else begin
			probe_q <= nxt;
			if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			node_q <= probe_in.node;
			last_q <= probe_in.now;
		end else if (hit && probe_in.upd) begin
			last_q <= probe_in.now;
		end
	end

	assign probe_out = probe_q;

endmodule

// ===== sv/can_heartbeat_liveness_table_unit.sv =====
// ----------------------------------------------------------------------------
// can_heartbeat_liveness_table_unit
// Classifies received CAN frames and tracks heartbeat nodes in a small table.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is either a received frame or a liveness
// query and yields exactly one result transfer. Start, stop, unknown and
// bad-DLC frames are classified at once. Heartbeats and queries send a probe
// down a row of SLOTS slot cells, one cell per cycle: a query or a heartbeat
// of a known node needs one pass; a heartbeat of a new node needs a second
// pass to claim the lowest free slot. The row of cells is walked by one item
// at a time, so input is taken only while the unit is idle; a finished result
// waits in the output register and the next item may be taken in the
// meantime. Slots are empty after reset; the lowest slot holding a node is
// the one refreshed and reported. Configuration writes are expected only
// while no item is in flight.
// ----------------------------------------------------------------------------
module can_heartbeat_liveness_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [chlt_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [chlt_pkg::CFG_W-1:0]    cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [chlt_pkg::ID_W-1:0]     frame_id,
	input  logic [chlt_pkg::DLC_W-1:0]    frame_dlc,
	input  logic [chlt_pkg::NODE_W-1:0]   node_id,
	input  logic [chlt_pkg::TIME_W-1:0]   now_ms,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [chlt_pkg::KIND_W-1:0]   result_kind,
	output logic                          known,
	output logic                          alive
);
	import chlt_pkg::*;

	// Configuration registers
	logic [ID_W-1:0]   start_id_q;
	logic [ID_W-1:0]   stop_id_q;
	logic [ID_W-1:0]   hb_id_q;
	logic [DLC_W-1:0]  min_dlc_q;
	logic [TIME_W-1:0] timeout_q;

	// Control
	state_t            state_q, state_d;
	logic [KIND_W-1:0] kind_q, kind_d;
	logic              known_q, known_d;
	logic              alive_q, alive_d;

	// Output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic              out_known_q;
	logic              out_alive_q;
	logic              load_out;

	// Row of slot cells
	probe_t            chain [SLOTS+1];
	probe_t            head;
	probe_t            tail;

	assign chain[0] = head;
	assign tail     = chain[SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_id_q <= '0;
			stop_id_q  <= ID_W'(1);
			hb_id_q    <= ID_W'(2);
			min_dlc_q  <= DLC_W'(1);
			timeout_q  <= TIME_W'(1000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_ID: start_id_q <= cfg_data[ID_W-1:0];
				REG_STOP_ID:  stop_id_q  <= cfg_data[ID_W-1:0];
				REG_HB_ID:    hb_id_q    <= cfg_data[ID_W-1:0];
				REG_MIN_DLC:  min_dlc_q  <= cfg_data[DLC_W-1:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data[TIME_W-1:0];
				default:      ; // ignore writes beyond the register list
			endcase
		end
	end

	// Next state, probe injection and result capture
	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		known_d  = known_q;
		alive_d  = alive_q;
		in_ready = (state_q == ST_IDLE);
		load_out = 1'b0;

		head      = '0;
		head.node = node_id;
		head.now  = now_ms;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					known_d = 1'b0;
					alive_d = 1'b0;
					if (operation == OP_QUERY) begin
						head.vld = 1'b1;
						state_d  = ST_LOOK;
					end else if (frame_id == start_id_q) begin
						kind_d  = KIND_START;
						state_d = ST_DONE;
					end else if (frame_id == stop_id_q) begin
						kind_d  = KIND_STOP;
						state_d = ST_DONE;
					end else if (frame_id == hb_id_q) begin
						if (frame_dlc >= min_dlc_q) begin
							head.vld = 1'b1;
							head.upd = 1'b1;
							state_d  = ST_LOOK;
						end else begin
							kind_d  = KIND_BAD_DLC;
							state_d = ST_DONE;
						end
					end else begin
						kind_d  = KIND_UNKNOWN;
						state_d = ST_DONE;
					end
				end
			end
			ST_LOOK: begin
				if (tail.vld) begin
					if (!tail.upd) begin
						kind_d  = KIND_QUERY;
						known_d = tail.found;
						alive_d = tail.found && tail.alive;
						state_d = ST_DONE;
					end else if (tail.found) begin
						kind_d  = KIND_STORED;
						state_d = ST_DONE;
					end else if (tail.free) begin
						// Send the claim pass for the lowest free slot
						head.vld   = 1'b1;
						head.claim = 1'b1;
						head.node  = tail.node;
						head.now   = tail.now;
						state_d    = ST_CLAIM;
					end else begin
						kind_d  = KIND_FULL;
						state_d = ST_DONE;
					end
				end
			end
			ST_CLAIM: begin
				if (tail.vld) begin
					kind_d  = KIND_STORED;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hold the result until the output register frees up
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		known_q <= known_d;
		alive_q <= alive_d;
		if (load_out) begin
			out_kind_q  <= kind_q;
			out_known_q <= known_q;
			out_alive_q <= alive_q;
		end
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_slot
		chlt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.timeout_ms (timeout_q),
			.probe_in   (chain[i]),
			.probe_out  (chain[i+1])
		);
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign known       = out_known_q;
	assign alive       = out_alive_q;

endmodule

// ===== bench/can_heartbeat_liveness_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// can_heartbeat_liveness_table_unit_tb
// Self-checking bench for the CAN heartbeat liveness table.
// ----------------------------------------------------------------------------
// A short directed part covers the reset settings, identifier priority, DLC
// limits, register masking, timeout extremes, clock wrap and a full table.
// The random part then sweeps several register settings with mostly
// heartbeats and queries of tracked nodes, plus start, stop and stray frames.
// Every input transfer runs through a local model of the slot table, and each
// result transfer is compared field by field with the oldest expected result.
// Both channels idle at random, with stretches of steady traffic.
// ----------------------------------------------------------------------------
module can_heartbeat_liveness_table_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import chlt_pkg::*;

	localparam int HALF_PERIOD     = 2;
	localparam int RESET_CYCLES    = 3;
	localparam int ROUNDS          = 6;
	localparam int ITEMS_PER_ROUND = 237;
	localparam int SETTLE_CYCLES   = 2 * SLOTS + 8;
	localparam int QUIET_LIMIT     = 2000;
	localparam int DLC_MAX         = 2 ** DLC_W - 1;

	localparam logic [CIDX_W-1:0] REG_FIRST_UNUSED = REG_TIMEOUT + 1'b1;

	typedef struct packed {
		logic              op;
		logic [ID_W-1:0]   id;
		logic [DLC_W-1:0]  dlc;
		logic [NODE_W-1:0] node;
		logic [TIME_W-1:0] now;
	} can_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              known;
		logic              alive;
	} verdict_t;

	// ------------------------------------------------------------------
	// Block ports; the inputs are driven to known values from time zero
	// ------------------------------------------------------------------
	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_we      = 1'b0;
	logic [CIDX_W-1:0]   cfg_index   = '0;
	logic [CFG_W-1:0]    cfg_data    = '0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                operation   = OP_FRAME;
	logic [ID_W-1:0]     frame_id    = '0;
	logic [DLC_W-1:0]    frame_dlc   = '0;
	logic [NODE_W-1:0]   node_id     = '0;
	logic [TIME_W-1:0]   now_ms      = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [KIND_W-1:0]   result_kind;
	logic                known;
	logic                alive;

	// ------------------------------------------------------------------
	// Local copy of the registers and the slot table (reset values)
	// ------------------------------------------------------------------
	logic [ID_W-1:0]   cfg_start   = 29'd0;
	logic [ID_W-1:0]   cfg_stop    = 29'd1;
	logic [ID_W-1:0]   cfg_hb      = 29'd2;
	logic [DLC_W-1:0]  cfg_min_dlc = 4'd1;
	logic [TIME_W-1:0] cfg_timeout = 32'd1000;

	logic              slot_used [SLOTS] = '{default: 1'b0};
	logic [NODE_W-1:0] slot_node [SLOTS];
	logic [TIME_W-1:0] slot_seen [SLOTS];

	verdict_t verdicts_due [$];

	int mismatches      = 0;
	int items_taken     = 0;
	int results_checked = 0;
	int settings_loaded = 0;
	int quiet_cycles    = 0;
	int alive_answers   = 0;
	int kind_tally [2 ** KIND_W] = '{default: 0};

	bit          source_steady = 1'b0;
	bit          sink_steady   = 1'b0;
	int unsigned stall_left    = 0;

	can_heartbeat_liveness_table_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.frame_id    (frame_id),
		.frame_dlc   (frame_dlc),
		.node_id     (node_id),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.known       (known),
		.alive       (alive)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Table model: classify one item and update the slots it touches
	// ------------------------------------------------------------------
	function automatic verdict_t track_item(input can_item_t it);
		verdict_t v;
		int       hit;
		int       vacant;
		v.kind  = KIND_UNKNOWN;
		v.known = 1'b0;
		v.alive = 1'b0;
		hit     = -1;
		vacant  = -1;
		// Walk from the top so the lowest matching and lowest free slot win.
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_node[i] == it.node)
				hit = i;
			if (!slot_used[i])
				vacant = i;
		end
		if (it.op == OP_QUERY) begin
			v.kind = KIND_QUERY;
			if (hit >= 0) begin
				v.known = 1'b1;
				// Age wraps modulo 2^32.
				v.alive = (TIME_W'(it.now - slot_seen[hit]) <= cfg_timeout);
			end
		end else if (it.id == cfg_start) begin
			v.kind = KIND_START;
		end else if (it.id == cfg_stop) begin
			v.kind = KIND_STOP;
		end else if (it.id == cfg_hb) begin
			if (it.dlc < cfg_min_dlc) begin
				v.kind = KIND_BAD_DLC;
			end else if (hit >= 0) begin
				slot_seen[hit] = it.now;
				v.kind = KIND_STORED;
			end else if (vacant >= 0) begin
				slot_used[vacant] = 1'b1;
				slot_node[vacant] = it.node;
				slot_seen[vacant] = it.now;
				v.kind = KIND_STORED;
			end else begin
				v.kind = KIND_FULL;
			end
		end
		return v;
	endfunction

	// Mirror one register write; out-of-range indexes are dropped.
	function automatic void apply_register(input logic [CIDX_W-1:0] idx,
	                                       input logic [CFG_W-1:0] data);
		case (idx)
		REG_START_ID: cfg_start   = data[ID_W-1:0];
		REG_STOP_ID:  cfg_stop    = data[ID_W-1:0];
		REG_HB_ID:    cfg_hb      = data[ID_W-1:0];
		REG_MIN_DLC:  cfg_min_dlc = data[DLC_W-1:0];
		REG_TIMEOUT:  cfg_timeout = data[TIME_W-1:0];
		default: ;
		endcase
	endfunction

	// Mostly short idles, now and then a long one.
	function automatic int unsigned pick_pause();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
	                             input logic [31:0] want);
		$display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want,
		         results_checked);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Input channel
	// ------------------------------------------------------------------
	// Hold valid and payload until the transfer, then predict. Valid stays
	// high when no pause follows, so back-to-back items never drop it.
	task automatic send_item(input logic op, input logic [ID_W-1:0] id,
	                         input logic [DLC_W-1:0] dlc,
	                         input logic [NODE_W-1:0] node,
	                         input logic [TIME_W-1:0] now);
		can_item_t   it;
		int unsigned pause;
		it = '{op, id, dlc, node, now};
		in_valid  <= 1'b1;
		operation <= op;
		frame_id  <= id;
		frame_dlc <= dlc;
		node_id   <= node;
		now_ms    <= now;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		verdicts_due.push_back(track_item(it));
		items_taken++;
		pause = source_steady ? 0 : pick_pause();
		if (pause != 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every outstanding result.
	task automatic drain();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Write all five registers plus one out-of-range index, with the unit idle.
	task automatic load_settings(input logic [CFG_W-1:0] start_v, stop_v, hb_v,
	                             dlc_v, timeout_v);
		logic [CIDX_W-1:0] idx [6];
		logic [CFG_W-1:0]  dat [6];
		drain();
		idx = '{REG_START_ID, REG_STOP_ID, REG_HB_ID, REG_MIN_DLC, REG_TIMEOUT,
		        REG_FIRST_UNUSED + CIDX_W'($urandom_range(0, 2))};
		dat = '{start_v, stop_v, hb_v, dlc_v, timeout_v, CFG_W'($urandom)};
		for (int k = 0; k < 6; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= dat[k];
			apply_register(idx[k], dat[k]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// ------------------------------------------------------------------
	// Result channel: check each transfer, then decide ready for next cycle
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (verdicts_due.size() == 0) begin
				flag_mismatch("result with nothing outstanding, kind", 32'(result_kind), 0);
			end else begin
				want = verdicts_due.pop_front();
				if (result_kind !== want.kind)
					flag_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
				if (known !== want.known)
					flag_mismatch("known", 32'(known), 32'(want.known));
				if (alive !== want.alive)
					flag_mismatch("alive", 32'(alive), 32'(want.alive));
				kind_tally[want.kind]++;
				if (want.alive)
					alive_answers++;
			end
			results_checked++;
		end
		// Flip between stalling and steady stretches now and then.
		if ($urandom_range(0, 499) == 0)
			sink_steady = !sink_steady;
		if (stall_left == 0 && !sink_steady && $urandom_range(0, 99) < 25)
			stall_left = pick_pause();
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer, %0d results outstanding",
			         quiet_cycles, verdicts_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------
	// Reset settings: start 0, stop 1, heartbeat 2, least DLC 1, timeout 1000.
	task automatic test_default_settings();
		send_item(OP_QUERY, '0, '0, 8'd0, 32'd0);                // empty table
		send_item(OP_FRAME, 29'd0, 4'd15, 8'hFF, 32'hFFFF_FFFF);
		send_item(OP_FRAME, 29'd1, 4'd0, 8'd0, 32'd0);
		send_item(OP_FRAME, 29'd2, 4'd0, 8'd0, 32'd50);           // short DLC
		send_item(OP_FRAME, 29'd2, 4'd1, 8'd0, 32'd100);          // claims slot 0
		send_item(OP_FRAME, 29'd3, 4'd8, 8'd0, 32'd0);
		send_item(OP_FRAME, 29'h1FFF_FFFF, 4'd8, 8'd0, 32'd0);
		send_item(OP_QUERY, 29'h1FFF_FFFF, 4'd15, 8'd0, 32'd1100); // age == timeout
		send_item(OP_QUERY, '0, '0, 8'd0, 32'd1101);               // one past it
	endtask

	// All-ones writes also check that the narrow registers drop upper bits.
	task automatic test_id_priority_and_dlc();
		load_settings('1, '1, '1, '1, '1);
		send_item(OP_FRAME, 29'h1FFF_FFFF, 4'd15, 8'd1, 32'd0);   // start wins
		load_settings('0, '1, '1, '1, '1);
		send_item(OP_FRAME, 29'h1FFF_FFFF, 4'd15, 8'd1, 32'd0);   // stop over heartbeat
		load_settings(32'd0, 32'd1, '1, '1, '1);
		send_item(OP_FRAME, 29'h1FFF_FFFF, 4'd14, 8'hFF, 32'd0);  // below DLC 15
		send_item(OP_FRAME, 29'h1FFF_FFFF, 4'd15, 8'hFF, 32'd5);  // node 255 tracked
		send_item(OP_QUERY, '0, '0, 8'hFF, 32'd4);                // largest age, still alive
		load_settings(32'd0, 32'd1, '1, 32'd0, 32'd0);
		send_item(OP_FRAME, 29'h1FFF_FFFF, 4'd0, 8'hFF, 32'd6);   // DLC 0 accepted
		send_item(OP_QUERY, '0, '0, 8'hFF, 32'd6);
		send_item(OP_QUERY, '0, '0, 8'hFF, 32'd7);                // zero timeout expired
	endtask

	// Age across the 2^32 wrap of the uptime counter.
	task automatic test_clock_wrap();
		load_settings(32'd0, 32'd1, 32'd2, 32'd1, 32'h200);
		send_item(OP_FRAME, 29'd2, 4'd8, 8'h5A, 32'hFFFF_FF00);
		send_item(OP_QUERY, '0, '0, 8'h5A, 32'h0000_0100);
		send_item(OP_QUERY, '0, '0, 8'h5A, 32'h0000_0101);
	endtask

	// Fill the remaining slots, then overflow with one more node.
	task automatic test_table_full();
		logic [NODE_W-1:0] fresh [5];
		fresh = '{8'h01, 8'h02, 8'h80, 8'h7F, 8'hA5};
		foreach (fresh[k])
			send_item(OP_FRAME, 29'd2, 4'd1, fresh[k], 32'd3000 + k);
		send_item(OP_FRAME, 29'd2, 4'd1, 8'hC3, 32'd3100);        // no room left
		send_item(OP_QUERY, '0, '0, 8'hC3, 32'd3100);
		send_item(OP_FRAME, 29'd2, 4'd1, 8'd0, 32'd3200);         // refresh still works
	endtask

	// ------------------------------------------------------------------
	// Random traffic over several register settings
	// ------------------------------------------------------------------
	task automatic test_random_traffic();
		logic              op;
		logic [ID_W-1:0]   id;
		logic [DLC_W-1:0]  dlc;
		logic [NODE_W-1:0] node;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] clock_ms;
		logic [CFG_W-1:0]  shared_id;
		int unsigned       pick;
		int unsigned       slot;
		clock_ms = $urandom;
		for (int round = 0; round < ROUNDS; round++) begin
			case (round)
			0: load_settings($urandom, $urandom, $urandom, $urandom,
			                 $urandom_range(0, 5000));
			// extremes: lowest and highest identifiers, DLC 0, zero timeout
			1: load_settings('0, '1, $urandom, '0, '0);
			2: load_settings($urandom, $urandom, '1, DLC_MAX, '1);
			// start and heartbeat share an identifier: start must win
			3: begin
				shared_id = $urandom;
				load_settings(shared_id, $urandom, shared_id, $urandom_range(0, 3),
				              $urandom);
			end
			// run the uptime across its wrap
			4: begin
				clock_ms = 32'hFFFF_F000;
				load_settings($urandom, $urandom, $urandom, $urandom_range(0, 8),
				              $urandom_range(500, 5000));
			end
			default: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
			endcase
			for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
				if (n % 40 == 0)
					source_steady = ($urandom_range(0, 3) == 0);
				// hold the sender once until the table has answered everything
				if (round == 2 && n == ITEMS_PER_ROUND / 2)
					drain();
				if (round == ROUNDS - 1 && $urandom_range(0, 19) == 0)
					clock_ms = $urandom;
				else
					clock_ms += $urandom_range(0, 600);
				op   = OP_FRAME;
				id   = ID_W'($urandom);
				dlc  = DLC_W'($urandom);
				node = NODE_W'($urandom);
				now  = clock_ms;
				slot = $urandom_range(0, SLOTS - 1);
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// heartbeat, mostly well formed and mostly for a tracked node
					id = cfg_hb;
					if ($urandom_range(0, 4) != 0)
						dlc = DLC_W'($urandom_range(cfg_min_dlc, DLC_MAX));
					if (slot_used[slot] && $urandom_range(0, 9) < 7)
						node = slot_node[slot];
				end else if (pick < 75) begin
					// query, with ages placed around the timeout boundary
					op = OP_QUERY;
					if (slot_used[slot] && $urandom_range(0, 3) != 0) begin
						node = slot_node[slot];
						case ($urandom_range(0, 4))
						0: now = slot_seen[slot];
						1: now = slot_seen[slot] + cfg_timeout;
						2: now = slot_seen[slot] + cfg_timeout + 1'b1;
						3: now = slot_seen[slot] + cfg_timeout - 1'b1;
						default: now = $urandom;
						endcase
					end
				end else if (pick < 83) begin
					id = cfg_start;
				end else if (pick < 91) begin
					id = cfg_stop;
				end
				send_item(op, id, dlc, node, now);
			end
		end
		source_steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_id_priority_and_dlc();
		test_clock_wrap();
		test_table_full();
		test_random_traffic();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d items under %0d register settings, %0d results checked",
		         items_taken, settings_loaded, results_checked);
		$display("start %0d stop %0d stored %0d full %0d bad-dlc %0d",
		         kind_tally[KIND_START], kind_tally[KIND_STOP], kind_tally[KIND_STORED],
		         kind_tally[KIND_FULL], kind_tally[KIND_BAD_DLC]);
		$display("unknown %0d query %0d (alive %0d)",
		         kind_tally[KIND_UNKNOWN], kind_tally[KIND_QUERY], alive_answers);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/chlt_pkg.sv
sv/chlt_cell.sv
sv/can_heartbeat_liveness_table_unit.sv
bench/can_heartbeat_liveness_table_unit_tb.sv
